/* rtl/scfp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the serial command frame parser
// Word formats, frame limits, command codes and field positions.
// ----------------------------------------------------------------------------
package scfp_pkg;

    // frame limits
    localparam int MAX_FRAME = 20;
    localparam int IDX_W     = $clog2(MAX_FRAME + 1);
    localparam int POS_W     = $clog2(MAX_FRAME);
    // decode looks at positions up to 15, so the view is at least that long
    localparam int VIEW_LEN  = (MAX_FRAME > 16) ? MAX_FRAME : 16;

    localparam logic [7:0] SYNC_BYTE      = 8'h7e;
    localparam logic [7:0] CMD_SEND       = 8'd2;
    localparam logic [7:0] CMD_FILTER     = 8'd3;
    localparam logic [7:0] MIN_FRAME_LEN  = 8'd3;
    localparam logic [7:0] MIN_SEND_LEN   = 8'd9;
    localparam logic [7:0] MAX_DATA_LEN   = 8'd17;
    localparam logic [7:0] MIN_FILTER_LEN = 8'd12;

    // frame positions
    localparam int POS_SYNC   = 0;
    localparam int POS_LEN    = 1;
    localparam int POS_CMD    = 2;
    localparam int POS_REMOTE = 3;
    localparam int POS_IDENT  = 4;
    localparam int POS_DATA   = 8;
    localparam int POS_MASK   = 3;
    localparam int POS_FILTER = 7;

    // input word kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // result actions
    localparam logic ACT_SEND   = 1'b0;
    localparam logic ACT_FILTER = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        action;
        logic        remote;
        logic [31:0] ident;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [31:0] filter_word;
        logic [31:0] mask_word;
    } result_t;

    // assembled frame as seen on the cycle of its last byte
    typedef struct packed {
        logic [7:0]                len;
        logic [VIEW_LEN-1:0][7:0]  bytes;
    } frame_t;

endpackage
`default_nettype wire

/* rtl/serial_command_frame_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_frame_parser: serial command frame parser, top level
// Input register, frame assembly, decode and result register.
// ----------------------------------------------------------------------------
// Each input word is a received serial byte or a timeout. The parser hunts for
// the 0x7E sync byte, takes the length byte and gathers the rest of the frame;
// on its last byte a send (command 2) or filter (command 3) result is issued,
// anything else is dropped and a timeout restarts the hunt. One word is taken
// every clock cycle unless a stalled result holds it back; the word that ends a
// frame passes through the input register, then through the single assembly
// and decode pass into the result register. A stalled result blocks only words
// that would end a frame with a result; other words keep flowing.
// ----------------------------------------------------------------------------
module serial_command_frame_parser
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire scfp_pkg::item_t item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output scfp_pkg::result_t    result
);

    logic               held_valid;
    scfp_pkg::item_t    held;
    logic               advance;
    logic               frame_done;
    scfp_pkg::frame_t   frame;
    logic               frame_ok;
    scfp_pkg::result_t  decoded;
    logic               produce;
    logic               res_valid_reg;
    logic               res_valid_next;
    scfp_pkg::result_t  res_reg;

    scfp_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    scfp_assembler u_assembler
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .held       (held),
        .frame_done (frame_done),
        .frame      (frame)
    );

    scfp_decoder u_decoder
    (
        .frame    (frame),
        .frame_ok (frame_ok),
        .result   (decoded)
    );

    // a word moves on unless it ends a frame with a result and the result slot is blocked
    assign produce = frame_done && frame_ok;
    assign advance = held_valid &&
                     (!res_valid_reg || !result_stall || !produce);

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance && produce)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            res_reg <= decoded;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef NO_ASSERTIONS
    // a decoded frame always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && produce) |=> result_valid)
    else $error("decoded frame did not reach the result register");

    // the input side stalls only while it holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> held_valid)
    else $error("input stalled with no held word");

    // a taken result with nothing new behind it empties the slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !(advance && produce)) |=> !result_valid)
    else $error("result repeated after it was taken");

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !(advance && produce))
    else $error("waiting result overwritten");
`endif

endmodule
`default_nettype wire

/* rtl/scfp_input_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_input_stage: input register
// Holds one incoming word until the assembler consumes it.
// ----------------------------------------------------------------------------
module scfp_input_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire scfp_pkg::item_t item,
    input  wire logic            advance,
    output logic                 held_valid,
    output scfp_pkg::item_t      held
);

    logic            valid_reg;
    logic            valid_next;
    scfp_pkg::item_t data_reg;
    logic            load;

    // stall only while a held word cannot move on
    assign item_stall = valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held       = data_reg;

endmodule
`default_nettype wire

/* rtl/scfp_assembler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_assembler: sync hunt and frame gathering
// Tracks the frame phase, stores frame bytes and flags the last byte.
// ----------------------------------------------------------------------------
module scfp_assembler
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire scfp_pkg::item_t held,
    output logic                 frame_done,
    output scfp_pkg::frame_t     frame
);

    scfp_pkg::phase_t              phase_reg;
    scfp_pkg::phase_t              phase_next;
    logic [7:0]                    len_reg;
    logic [7:0]                    len_next;
    logic [scfp_pkg::IDX_W-1:0]    idx_reg;
    logic [scfp_pkg::IDX_W-1:0]    idx_next;
    logic [scfp_pkg::IDX_W-1:0]    idx_inc;
    logic [7:0]                    store_reg [scfp_pkg::MAX_FRAME];
    logic                          wr_en;
    logic [scfp_pkg::POS_W-1:0]    wr_pos;
    logic                          done;

    assign idx_inc = idx_reg + scfp_pkg::IDX_W'(1);

    // next phase, store write and end-of-frame flag
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_pos     = '0;
        done       = 1'b0;
        if (held.kind == scfp_pkg::KIND_TIMEOUT)
        begin
            phase_next = scfp_pkg::PH_HUNT;
            idx_next   = '0;
        end
        else
        begin
            case (phase_reg)
                scfp_pkg::PH_HUNT:
                begin
                    if (held.rx_byte == scfp_pkg::SYNC_BYTE)
                    begin
                        wr_en      = 1'b1;
                        wr_pos     = scfp_pkg::POS_W'(scfp_pkg::POS_SYNC);
                        phase_next = scfp_pkg::PH_LEN;
                    end
                end
                scfp_pkg::PH_LEN:
                begin
                    wr_en    = 1'b1;
                    wr_pos   = scfp_pkg::POS_W'(scfp_pkg::POS_LEN);
                    len_next = held.rx_byte;
                    if ((held.rx_byte > 8'(scfp_pkg::MAX_FRAME)) ||
                        (held.rx_byte < scfp_pkg::MIN_FRAME_LEN))
                    begin
                        phase_next = scfp_pkg::PH_HUNT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_BODY;
                        idx_next   = scfp_pkg::IDX_W'(scfp_pkg::POS_CMD);
                    end
                end
                scfp_pkg::PH_BODY:
                begin
                    if ((8'(idx_reg) < len_reg) &&
                        (idx_reg < scfp_pkg::IDX_W'(scfp_pkg::MAX_FRAME)))
                    begin
                        wr_en    = 1'b1;
                        wr_pos   = idx_reg[scfp_pkg::POS_W-1:0];
                        idx_next = idx_inc;
                        if (8'(idx_inc) >= len_reg)
                        begin
                            done       = 1'b1;
                            phase_next = scfp_pkg::PH_HUNT;
                            idx_next   = '0;
                        end
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_HUNT;
                        idx_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = scfp_pkg::PH_HUNT;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= scfp_pkg::PH_HUNT;
            len_reg   <= '0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    // frame byte store
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            store_reg[wr_pos] <= held.rx_byte;
        end
    end

    // stored bytes with the byte now arriving laid over its slot
    always_comb
    begin
        frame.len   = len_reg;
        frame.bytes = '0;
        for (int k = 0; k < scfp_pkg::MAX_FRAME; k++)
        begin
            if (wr_en && (wr_pos == scfp_pkg::POS_W'(k)))
            begin
                frame.bytes[k] = held.rx_byte;
            end
            else
            begin
                frame.bytes[k] = store_reg[k];
            end
        end
    end

    assign frame_done = done && (held.kind == scfp_pkg::KIND_BYTE);

endmodule
`default_nettype wire

/* rtl/scfp_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_decoder: command decode
// Judges a complete frame and builds the transmit or filter result.
// ----------------------------------------------------------------------------
module scfp_decoder
(
    input  wire scfp_pkg::frame_t frame,
    output logic                  frame_ok,
    output scfp_pkg::result_t     result
);

    logic [7:0] cmd;
    logic [3:0] n;

    assign cmd = frame.bytes[scfp_pkg::POS_CMD];
    // data byte count, meaningful only for lengths 9 to 17
    assign n   = 4'(frame.len - scfp_pkg::MIN_SEND_LEN);

    always_comb
    begin
        frame_ok = 1'b0;
        result   = '0;
        case (cmd)
            scfp_pkg::CMD_SEND:
            begin
                if (frame.len >= scfp_pkg::MIN_SEND_LEN)
                begin
                    result.action = scfp_pkg::ACT_SEND;
                    result.ident  = {frame.bytes[scfp_pkg::POS_IDENT + 3],
                                     frame.bytes[scfp_pkg::POS_IDENT + 2],
                                     frame.bytes[scfp_pkg::POS_IDENT + 1],
                                     frame.bytes[scfp_pkg::POS_IDENT]};
                    if (frame.bytes[scfp_pkg::POS_REMOTE] == 8'd0)
                    begin
                        // data frame: length capped at eight data bytes
                        if (frame.len <= scfp_pkg::MAX_DATA_LEN)
                        begin
                            frame_ok   = 1'b1;
                            result.dlc = n;
                            for (int k = 0; k < 8; k++)
                            begin
                                if (4'(k) < n)
                                begin
                                    result.payload[8*k +: 8] =
                                        frame.bytes[scfp_pkg::POS_DATA + k];
                                end
                            end
                        end
                    end
                    else
                    begin
                        frame_ok      = 1'b1;
                        result.remote = 1'b1;
                    end
                end
            end
            scfp_pkg::CMD_FILTER:
            begin
                if (frame.len >= scfp_pkg::MIN_FILTER_LEN)
                begin
                    frame_ok           = 1'b1;
                    result.action      = scfp_pkg::ACT_FILTER;
                    result.filter_word = {frame.bytes[scfp_pkg::POS_FILTER + 3][4:0],
                                          frame.bytes[scfp_pkg::POS_FILTER + 2],
                                          frame.bytes[scfp_pkg::POS_FILTER + 1],
                                          frame.bytes[scfp_pkg::POS_FILTER],
                                          3'b000};
                    result.mask_word   = {frame.bytes[scfp_pkg::POS_MASK + 3][4:0],
                                          frame.bytes[scfp_pkg::POS_MASK + 2],
                                          frame.bytes[scfp_pkg::POS_MASK + 1],
                                          frame.bytes[scfp_pkg::POS_MASK],
                                          3'b000};
                end
            end
            default:
            begin
                frame_ok = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the serial command frame parser
// A short table of directed words (stray bytes, bad lengths, timeouts, a
// remote send and a filter load at their extremes) is followed by about a
// thousand random words, mostly well-formed frames with random content. Every
// accepted word is run through a local frame predictor; each result is
// checked field by field against the oldest expectation. Both handshakes
// idle and stall at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_WORDS   = 1000;
    localparam int MAX_GAP        = 13;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int PRINT_LIMIT    = 50;

    // short names for the directed table
    localparam logic K_BYTE = scfp_pkg::KIND_BYTE;
    localparam logic K_TMO  = scfp_pkg::KIND_TIMEOUT;
    localparam logic A_SEND = scfp_pkg::ACT_SEND;
    localparam logic A_FILT = scfp_pkg::ACT_FILTER;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_FIXED
    } row_mode_t;

    typedef struct packed {
        row_mode_t   mode;
        logic        kind;
        logic [7:0]  data;
        logic        action;
        logic        remote;
        logic [31:0] ident;
        logic [31:0] filter_word;
        logic [31:0] mask_word;
    } dir_row_t;

    localparam int DIR_ROWS = 30;
    localparam dir_row_t DIRECTED_WORDS [DIR_ROWS] = '{
        // straight after reset: stray byte, then a timeout that carries the sync value
        '{ROW_QUIET,   K_BYTE, 8'h00, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_QUIET,   K_TMO,  8'h7e, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        // zero length and an over-long length
        '{ROW_QUIET,   K_BYTE, 8'h7e, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_QUIET,   K_BYTE, 8'h00, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_QUIET,   K_BYTE, 8'h7e, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_QUIET,   K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        // timeout in the middle of a frame
        '{ROW_QUIET,   K_BYTE, 8'h7e, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_QUIET,   K_BYTE, 8'h05, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_QUIET,   K_TMO,  8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        // shortest remote send, all-ones identifier
        '{ROW_PREDICT, K_BYTE, 8'h7e, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h09, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h02, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h01, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_FIXED,   K_BYTE, 8'h5a, A_SEND, 1'b1, 32'hffff_ffff, 32'h0, 32'h0},
        // shortest filter load: full mask, filter word loses its top bit in the shift
        '{ROW_PREDICT, K_BYTE, 8'h7e, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h0c, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h03, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'hff, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h01, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h00, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h00, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_PREDICT, K_BYTE, 8'h20, A_SEND, 1'b0, 32'h0, 32'h0, 32'h0},
        '{ROW_FIXED,   K_BYTE, 8'h00, A_FILT, 1'b0, 32'h0, 32'h0000_0008,
          32'hffff_fff8}
    };

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    scfp_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    scfp_pkg::result_t result;

    // predictor state
    scfp_pkg::phase_t rx_phase = scfp_pkg::PH_HUNT;
    logic [7:0]       rx_len   = 8'd0;
    int               rx_pos   = 0;
    logic [7:0]       rx_bytes [scfp_pkg::MAX_FRAME];

    scfp_pkg::result_t pending_results [$];
    scfp_pkg::item_t   stim_words [$];
    int                mismatches   = 0;
    int                quiet_cycles = 0;
    int                hold_left    = 0;
    bit                send_calm    = 1'b0;
    bit                recv_calm    = 1'b0;

    serial_command_frame_parser i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // little-endian word from four gathered bytes
    function automatic logic [31:0] le_word(int pos);
        return {rx_bytes[pos + 3], rx_bytes[pos + 2], rx_bytes[pos + 1], rx_bytes[pos]};
    endfunction

    // judge a complete frame; 1 when it yields a result
    function automatic bit decode_frame(output scfp_pkg::result_t r);
        int n;
        r = '0;
        if (rx_bytes[scfp_pkg::POS_CMD] == scfp_pkg::CMD_SEND)
        begin
            if (rx_len < scfp_pkg::MIN_SEND_LEN)
                return 1'b0;
            if (rx_bytes[scfp_pkg::POS_REMOTE] == 8'd0)
            begin
                if (rx_len > scfp_pkg::MAX_DATA_LEN)
                    return 1'b0;
                n = int'(rx_len - scfp_pkg::MIN_SEND_LEN);
                r.dlc = 4'(n);
                for (int k = 0; k < n; k++)
                    r.payload[8 * k +: 8] = rx_bytes[scfp_pkg::POS_DATA + k];
            end
            else
            begin
                r.remote = 1'b1;
            end
            r.action = scfp_pkg::ACT_SEND;
            r.ident  = le_word(scfp_pkg::POS_IDENT);
            return 1'b1;
        end
        if (rx_bytes[scfp_pkg::POS_CMD] == scfp_pkg::CMD_FILTER)
        begin
            if (rx_len < scfp_pkg::MIN_FILTER_LEN)
                return 1'b0;
            r.action      = scfp_pkg::ACT_FILTER;
            r.filter_word = le_word(scfp_pkg::POS_FILTER) << 3;
            r.mask_word   = le_word(scfp_pkg::POS_MASK) << 3;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the frame predictor by one accepted word
    function automatic bit parse_word(scfp_pkg::item_t w, output scfp_pkg::result_t r);
        r = '0;
        if (w.kind == scfp_pkg::KIND_TIMEOUT)
        begin
            rx_phase = scfp_pkg::PH_HUNT;
            rx_pos   = 0;
            return 1'b0;
        end
        case (rx_phase)
            scfp_pkg::PH_HUNT:
            begin
                if (w.rx_byte == scfp_pkg::SYNC_BYTE)
                begin
                    rx_bytes[scfp_pkg::POS_SYNC] = w.rx_byte;
                    rx_phase                     = scfp_pkg::PH_LEN;
                end
            end
            scfp_pkg::PH_LEN:
            begin
                rx_bytes[scfp_pkg::POS_LEN] = w.rx_byte;
                rx_len                      = w.rx_byte;
                if (w.rx_byte > scfp_pkg::MAX_FRAME || w.rx_byte < scfp_pkg::MIN_FRAME_LEN)
                begin
                    rx_phase = scfp_pkg::PH_HUNT;
                    rx_pos   = 0;
                end
                else
                begin
                    rx_phase = scfp_pkg::PH_BODY;
                    rx_pos   = scfp_pkg::POS_CMD;
                end
            end
            default:
            begin
                rx_bytes[rx_pos] = w.rx_byte;
                rx_pos++;
                if (rx_pos >= rx_len)
                begin
                    rx_phase = scfp_pkg::PH_HUNT;
                    rx_pos   = 0;
                    return decode_frame(r);
                end
            end
        endcase
        return 1'b0;
    endfunction

    // queue one random sequence; returns the words that count towards the total
    function automatic int queue_random_words();
        int              pick;
        int              flavour;
        int              len;
        int              cut;
        int              pushed = 0;
        logic [7:0]      cmd;
        logic [7:0]      flag;
        scfp_pkg::item_t w;
        pick = $urandom_range(0, 99);
        w.kind = scfp_pkg::KIND_BYTE;
        // line noise: stray bytes and timeouts, not counted towards the total
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 4))
            begin
                w.kind    = ($urandom_range(0, 3) == 0);
                w.rx_byte = 8'($urandom_range(0, 255));
                stim_words.push_back(w);
            end
            return 0;
        end
        w.rx_byte = scfp_pkg::SYNC_BYTE;
        stim_words.push_back(w);
        pushed++;
        // length byte outside the frame limits
        if (pick < 16)
        begin
            if ($urandom_range(0, 1) == 0)
                w.rx_byte = 8'($urandom_range(0, scfp_pkg::MIN_FRAME_LEN - 1));
            else
                w.rx_byte = 8'($urandom_range(scfp_pkg::MAX_FRAME + 1, 255));
            stim_words.push_back(w);
            return pushed + 1;
        end
        flavour = $urandom_range(0, 9);
        flag    = 8'($urandom_range(0, 255));
        if (flavour < 4)
        begin
            cmd  = scfp_pkg::CMD_SEND;
            flag = 8'd0;
            len  = $urandom_range(scfp_pkg::MIN_SEND_LEN, scfp_pkg::MAX_DATA_LEN);
        end
        else if (flavour < 6)
        begin
            cmd  = scfp_pkg::CMD_SEND;
            flag = 8'($urandom_range(1, 255));
            len  = $urandom_range(scfp_pkg::MIN_SEND_LEN, scfp_pkg::MAX_FRAME);
        end
        else if (flavour < 9)
        begin
            cmd = scfp_pkg::CMD_FILTER;
            len = $urandom_range(scfp_pkg::MIN_FILTER_LEN, scfp_pkg::MAX_FRAME);
        end
        else
        begin
            cmd = 8'($urandom_range(0, 255));
            len = $urandom_range(scfp_pkg::MIN_FRAME_LEN, scfp_pkg::MAX_FRAME);
        end
        // now and then a random length, which the command may not accept
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(scfp_pkg::MIN_FRAME_LEN, scfp_pkg::MAX_FRAME);
        // rarely a timeout breaks the frame
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len - 1) : len;
        for (int p = 1; p < len; p++)
        begin
            if (p == cut)
            begin
                w.kind    = scfp_pkg::KIND_TIMEOUT;
                w.rx_byte = 8'($urandom_range(0, 255));
                stim_words.push_back(w);
                w.kind    = scfp_pkg::KIND_BYTE;
                pushed++;
            end
            case (p)
                scfp_pkg::POS_LEN:    w.rx_byte = 8'(len);
                scfp_pkg::POS_CMD:    w.rx_byte = cmd;
                scfp_pkg::POS_REMOTE: w.rx_byte = flag;
                default:              w.rx_byte = 8'($urandom_range(0, 255));
            endcase
            stim_words.push_back(w);
            pushed++;
        end
        return pushed;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // compare one accepted result with the oldest expectation
    task automatic check_result(scfp_pkg::result_t got);
        scfp_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected: %h", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.action !== want.action)
            report_mismatch($sformatf("action %h, expected %h", got.action, want.action));
        if (got.remote !== want.remote)
            report_mismatch($sformatf("remote %h, expected %h", got.remote, want.remote));
        if (got.ident !== want.ident)
            report_mismatch($sformatf("ident %h, expected %h", got.ident, want.ident));
        if (got.dlc !== want.dlc)
            report_mismatch($sformatf("dlc %h, expected %h", got.dlc, want.dlc));
        if (got.payload !== want.payload)
            report_mismatch($sformatf("payload %h, expected %h", got.payload, want.payload));
        if (got.filter_word !== want.filter_word)
            report_mismatch($sformatf("filter_word %h, expected %h",
                                      got.filter_word, want.filter_word));
        if (got.mask_word !== want.mask_word)
            report_mismatch($sformatf("mask_word %h, expected %h",
                                      got.mask_word, want.mask_word));
    endtask

    // offer one word after a random gap and wait until it is taken
    task automatic send_word(scfp_pkg::item_t w);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
    endtask

    // result side: take, check, then hold off for a random stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid === 1'b1 && result_stall == 1'b0)
            begin
                check_result(result);
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                hold_left = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            result_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        scfp_pkg::item_t   w;
        scfp_pkg::result_t predicted;
        scfp_pkg::result_t want;
        dir_row_t          row;
        int                frame_words;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row       = DIRECTED_WORDS[i];
            w.kind    = row.kind;
            w.rx_byte = row.data;
            send_word(w);
            case (row.mode)
                ROW_PREDICT:
                begin
                    if (parse_word(w, predicted))
                        pending_results.push_back(predicted);
                end
                ROW_FIXED:
                begin
                    void'(parse_word(w, predicted));
                    want             = '0;
                    want.action      = row.action;
                    want.remote      = row.remote;
                    want.ident       = row.ident;
                    want.filter_word = row.filter_word;
                    want.mask_word   = row.mask_word;
                    pending_results.push_back(want);
                end
                default:
                begin
                    void'(parse_word(w, predicted));
                end
            endcase
        end

        // random frames and noise
        frame_words = 0;
        while (frame_words < RANDOM_WORDS)
        begin
            frame_words += queue_random_words();
            while (stim_words.size() != 0)
            begin
                w = stim_words.pop_front();
                send_word(w);
                if (parse_word(w, predicted))
                    pending_results.push_back(predicted);
            end
        end
        item_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
